// ----- rtl/dcsd_pkg.sv -----
package dcsd_pkg;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] stamp_us;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        last;
      logic [7:0]  gear;
      logic [7:0]  code;
      logic [7:0]  check;
      logic        check_ok;
      logic [3:0]  entry_index;
      logic [4:0]  entry_total;
      logic [22:0] update_ms;
      logic [31:0] groups_seen;
      logic [31:0] bad_checks;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMPARE,
      ST_REPORT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_GEAR,
      PH_DATA,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic rotate;
      logic clr_found;
      logic commit;
      logic wr_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic miss;
   } cell_stat_type;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERBYTE_MIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERGROUP_GAP = 1'd1;

   localparam logic [19:0] INTERBYTE_MIN_RST  = 20'd2000;
   localparam logic [23:0] INTERGROUP_GAP_RST = 24'd50000;

   localparam logic [7:0] TOP_GEAR  = 8'd6;
   localparam logic [3:0] GEAR_NONE = 4'd15;

   // stamp / 1000 == ((stamp >> 3) * MS_MAGIC) >> MS_SHIFT for all 32-bit stamps
   localparam logic [28:0] MS_MAGIC = 29'd274877907;
   localparam int          MS_SHIFT = 35;
   localparam int          MS_W     = 23;
   localparam int          PROD_W   = 58;

endpackage

// ----- rtl/dcsd_cell.sv -----
module dcsd_cell #(
   parameter int N   = 16,
   parameter int IDX = 0,
   localparam int CW = $clog2(N + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dcsd_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              probe,
   input  logic [CW-1:0]           wr_idx,
   input  logic [CW-1:0]           step,
   input  logic [CW-1:0]           ccount,
   input  logic [CW-1:0]           scount,
   input  logic [7:0]              s_next,
   output logic [7:0]              s_data,
   output dcsd_pkg::cell_stat_type stat
);
   import dcsd_pkg::*;

   localparam logic [CW:0]   MY_POS = (CW + 1)'(IDX);
   localparam logic [CW:0]   RING_N = (CW + 1)'(N);
   localparam logic [CW-1:0] MY_IDX = CW'(IDX);

   logic [7:0] c_data_ff, c_data_in;
   logic [7:0] s_data_ff, s_data_in;
   logic       found_ff, found_in;
   logic       hit_ff, hit_in;
   logic       c_valid, s_valid;
   logic [CW:0] orig_sum, orig;

   // position of the status entry currently parked in this cell
   always_comb begin
      orig_sum = MY_POS + {1'b0, step};
      orig     = (orig_sum >= RING_N) ? (orig_sum - RING_N) : orig_sum;
      c_valid  = MY_POS < {1'b0, ccount};
      s_valid  = orig < {1'b0, scount};
   end

   always_comb begin
      hit_in = c_valid && (c_data_ff == probe);

      found_in = found_ff;
      if (ctrl.clr_found) begin
         found_in = 1'b0;
      end else if (ctrl.rotate && s_valid && (c_data_ff == s_data_ff)) begin
         found_in = 1'b1;
      end

      s_data_in = s_data_ff;
      if (ctrl.commit) begin
         s_data_in = c_data_ff;
      end else if (ctrl.rotate) begin
         s_data_in = s_next;
      end

      c_data_in = c_data_ff;
      if (ctrl.wr_en && (wr_idx == MY_IDX)) begin
         c_data_in = probe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      c_data_ff <= c_data_in;
      s_data_ff <= s_data_in;
   end

   assign s_data    = s_data_ff;
   assign stat.hit  = hit_ff;
   assign stat.miss = c_valid && !found_ff;

endmodule

// ----- rtl/diag_code_stream_deframer_unit.sv -----
// channel  | ports                        | direction | accepted when
// ---------+------------------------------+-----------+-------------------------
// request  | req_valid req_stall req_data | in        | req_valid && !req_stall
// response | rsp_valid rsp_stall rsp_data | out       | rsp_valid && !rsp_stall
// config   | csr_we csr_index csr_wdata   | in        | csr_we
//
// One byte at a time. A byte that finishes no group passes through EVAL and back to IDLE;
// a group that leaves the code cycle open goes on to REPORT and its response beat. A group
// that closes the cycle rotates the status ring through all MAX_CODES cells in COMPARE,
// and a commit rotates it once more in EMIT to emit entries.
// Reset is synchronous; code lists hold no reset value and are read only under counts.
// A stalled response holds the block in its report or emit step.
module diag_code_stream_deframer_unit #(
   parameter int MAX_CODES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dcsd_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dcsd_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [dcsd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dcsd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dcsd_pkg::*;

   localparam int          CW      = $clog2(MAX_CODES + 1);
   localparam logic [CW-1:0] N_CNT = CW'(MAX_CODES);

   logic [19:0]  min_ff;
   logic [23:0]  gap_ff;
   state_type    state_ff, state_in;
   req_type      in_ff;
   logic [31:0]  prev_stamp_ff;
   phase_type    phase_ff;
   logic [2:0]   held_gear_ff;
   logic [7:0]   held_data_ff;
   logic [2:0]   cycle_gear_ff;
   logic [CW-1:0] ccount_ff;
   logic [CW-1:0] scount_ff;
   logic [3:0]   status_gear_ff;
   logic [MS_W-1:0] status_time_ff;
   logic [31:0]  groups_ff;
   logic [31:0]  errors_ff;
   logic         ok_ff;
   logic         commit_pend_ff;
   logic [CW-1:0] step_ff;
   logic [PROD_W-1:0] prod_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;

   logic [31:0]  elapsed;
   logic         window, restart, is_gear, finish, chk_ok;
   phase_type    phase_eff;
   logic [7:0]   sum8;
   logic         any_hit, any_miss, close, differs, step_done, out_free;

   logic         accept_req, do_finish, good_grp, plain_append, start_cmp;
   logic         cmp_run, cmp_end, do_commit, load_report;
   logic         emit_run, emit_vis, load_entry, emit_adv;
   logic         entry_last;
   cell_ctrl_type ctrl;
   logic [CW-1:0] wr_idx;

   logic [MAX_CODES-1:0] hit_vec, miss_vec;
   logic [7:0]           s_ring [MAX_CODES];
   cell_stat_type        stat [MAX_CODES];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_CODES; gi++) begin : g_cell
         dcsd_cell #(
            .N   (MAX_CODES),
            .IDX (gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .probe  (held_data_ff),
            .wr_idx (wr_idx),
            .step   (step_ff),
            .ccount (ccount_ff),
            .scount (scount_ff),
            .s_next (s_ring[(gi + 1) % MAX_CODES]),
            .s_data (s_ring[gi]),
            .stat   (stat[gi])
         );
         assign hit_vec[gi]  = stat[gi].hit;
         assign miss_vec[gi] = stat[gi].miss;
      end
   endgenerate

   always_comb begin
      elapsed   = in_ff.stamp_us - prev_stamp_ff;
      window    = (elapsed > {12'd0, min_ff}) && (elapsed < {8'd0, gap_ff});
      restart   = (prev_stamp_ff != 32'd0) && (elapsed > {8'd0, gap_ff});
      is_gear   = in_ff.rx_byte <= TOP_GEAR;
      phase_eff = restart ? PH_GEAR : phase_ff;
      finish    = (phase_eff == PH_CHECK) && window;
      sum8      = {5'd0, held_gear_ff} + held_data_ff;
      chk_ok    = in_ff.rx_byte == sum8;
      any_hit   = |hit_vec;
      any_miss  = |miss_vec;
      close     = any_hit || ((ccount_ff != '0) && (held_gear_ff != cycle_gear_ff));
      differs   = ({1'b0, cycle_gear_ff} != status_gear_ff) || (ccount_ff != scount_ff)
                  || any_miss;
      step_done = step_ff == N_CNT;
      out_free  = !rsp_valid_ff || !rsp_stall;
      entry_last = ((CW + 1)'(step_ff) + (CW + 1)'(1)) == {1'b0, scount_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!finish) state_in = ST_IDLE;
            else if (chk_ok && close) state_in = ST_COMPARE;
            else state_in = ST_REPORT;
         end
         ST_COMPARE: begin
            if (step_done) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) state_in = commit_pend_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (step_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      accept_req   = (state_ff == ST_IDLE) && req_valid;
      do_finish    = (state_ff == ST_EVAL) && finish;
      good_grp     = do_finish && chk_ok;
      plain_append = good_grp && !close && (ccount_ff < N_CNT);
      start_cmp    = good_grp && close;
      cmp_run      = (state_ff == ST_COMPARE) && !step_done;
      cmp_end      = (state_ff == ST_COMPARE) && step_done;
      do_commit    = cmp_end && differs;
      load_report  = (state_ff == ST_REPORT) && out_free;
      emit_run     = (state_ff == ST_EMIT) && !step_done;
      emit_vis     = emit_run && (step_ff < scount_ff);
      load_entry   = emit_vis && out_free;
      emit_adv     = emit_run && (!emit_vis || out_free);

      ctrl.rotate    = cmp_run || emit_adv;
      ctrl.clr_found = start_cmp;
      ctrl.commit    = do_commit;
      ctrl.wr_en     = plain_append || cmp_end;
      wr_idx         = cmp_end ? '0 : ccount_ff;
   end

   assign req_stall = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff         <= INTERBYTE_MIN_RST;
         gap_ff         <= INTERGROUP_GAP_RST;
         state_ff       <= ST_IDLE;
         prev_stamp_ff  <= 32'd0;
         phase_ff       <= PH_GEAR;
         held_gear_ff   <= 3'd0;
         held_data_ff   <= 8'd0;
         cycle_gear_ff  <= 3'd0;
         ccount_ff      <= '0;
         scount_ff      <= '0;
         status_gear_ff <= GEAR_NONE;
         status_time_ff <= '0;
         groups_ff      <= 32'd0;
         errors_ff      <= 32'd0;
         ok_ff          <= 1'b0;
         commit_pend_ff <= 1'b0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_INTERBYTE_MIN:  min_ff <= csr_wdata[19:0];
               CSR_INTERGROUP_GAP: gap_ff <= csr_wdata[23:0];
               default: ;
            endcase
         end

         if (state_ff == ST_EVAL) begin
            prev_stamp_ff <= in_ff.stamp_us;
            case (phase_eff)
               PH_DATA: begin
                  if (window) begin
                     held_data_ff <= in_ff.rx_byte;
                     phase_ff     <= PH_CHECK;
                  end else if (is_gear) begin
                     held_gear_ff <= in_ff.rx_byte[2:0];
                  end else begin
                     phase_ff <= PH_GEAR;
                  end
               end
               PH_CHECK: begin
                  phase_ff <= PH_GEAR;
               end
               default: begin
                  if (is_gear) begin
                     held_gear_ff <= in_ff.rx_byte[2:0];
                     phase_ff     <= PH_DATA;
                  end else begin
                     phase_ff <= PH_GEAR;
                  end
               end
            endcase
         end

         if (do_finish) begin
            groups_ff      <= groups_ff + 32'd1;
            errors_ff      <= errors_ff + {31'd0, !chk_ok};
            ok_ff          <= chk_ok;
            commit_pend_ff <= 1'b0;
         end

         if (good_grp && (ccount_ff == '0)) cycle_gear_ff <= held_gear_ff;
         if (plain_append) ccount_ff <= ccount_ff + CW'(1);

         if (cmp_end) begin
            cycle_gear_ff  <= held_gear_ff;
            ccount_ff      <= CW'(1);
            commit_pend_ff <= differs;
         end
         if (do_commit) begin
            status_gear_ff <= {1'b0, cycle_gear_ff};
            scount_ff      <= ccount_ff;
            status_time_ff <= prod_ff[MS_SHIFT +: MS_W];
         end

         if (start_cmp || load_report) begin
            step_ff <= '0;
         end else if (ctrl.rotate) begin
            step_ff <= step_ff + CW'(1);
         end

         if (load_report || load_entry) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) in_ff <= req_data;
      prod_ff <= {29'd0, in_ff.stamp_us[31:3]} * {29'd0, MS_MAGIC};

      if (load_report) begin
         rsp_ff.kind        <= 1'b0;
         rsp_ff.last        <= !commit_pend_ff;
         rsp_ff.gear        <= {5'd0, held_gear_ff};
         rsp_ff.code        <= held_data_ff;
         rsp_ff.check       <= in_ff.rx_byte;
         rsp_ff.check_ok    <= ok_ff;
         rsp_ff.entry_index <= 4'd0;
         rsp_ff.entry_total <= 5'd0;
         rsp_ff.update_ms   <= '0;
         rsp_ff.groups_seen <= groups_ff;
         rsp_ff.bad_checks  <= errors_ff;
      end else if (load_entry) begin
         rsp_ff.kind        <= 1'b1;
         rsp_ff.last        <= entry_last;
         rsp_ff.gear        <= {4'd0, status_gear_ff};
         rsp_ff.code        <= s_ring[0];
         rsp_ff.check       <= 8'd0;
         rsp_ff.check_ok    <= 1'b0;
         rsp_ff.entry_index <= 4'(step_ff);
         rsp_ff.entry_total <= 5'(scount_ff);
         rsp_ff.update_ms   <= status_time_ff;
         rsp_ff.groups_seen <= groups_ff;
         rsp_ff.bad_checks  <= errors_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_status_count: assert property (@(posedge clock) disable iff (reset)
      (status_gear_ff != GEAR_NONE) |-> (scount_ff != '0))
      else $error("committed status without codes");

   a_commit_restart: assert property (@(posedge clock) disable iff (reset)
      do_commit |=> (ccount_ff == CW'(1)) && (scount_ff != '0))
      else $error("cycle not restarted after commit");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && step_done) |=> (state_ff == ST_IDLE))
      else $error("emit did not end after full ring turn");

   a_eval_after_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> $past(req_valid && !req_stall))
      else $error("evaluation without request beat");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import dcsd_pkg::*;

   localparam int CODE_SLOTS = 16;
   localparam int SETTLE_CYCLES = 2 * CODE_SLOTS + 12;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   diag_code_stream_deframer_unit #(.MAX_CODES(CODE_SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // deframer state as the line should see it
   logic [19:0] win_min = INTERBYTE_MIN_RST;
   logic [23:0] gap_max = INTERGROUP_GAP_RST;
   phase_type ph = PH_GEAR;
   logic [7:0] hold_gear = '0;
   logic [7:0] hold_code = '0;
   logic [31:0] last_stamp = '0;
   logic [7:0] cur_gear = '0;
   int cur_n = 0;
   logic [7:0] cur_codes [CODE_SLOTS];
   logic [7:0] stat_gear = {4'd0, GEAR_NONE};
   int stat_n = 0;
   logic [7:0] stat_codes [CODE_SLOTS];
   logic [31:0] grp_total = '0;
   logic [31:0] bad_total = '0;

   rsp_type line_reports [$];
   rsp_type staged;
   bit staged_full = 0;
   rsp_type want_rsp;
   int mismatch_count = 0;
   int bytes_sent = 0;
   logic [31:0] line_time = 32'd95000;

   // cycle replay memory for the stimulus
   logic [7:0] mem_gear = '0;
   int mem_k = 0;
   logic [7:0] mem_codes [CODE_SLOTS+1];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // holds back one report so the final one of a byte can carry last
   task automatic stage_report(input rsp_type r);
      if (staged_full) line_reports.push_back(staged);
      staged = r;
      staged_full = 1;
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic [31:0] stamp);
      logic [31:0] elapsed;
      logic [7:0] sum;
      logic in_win, good, seen, hit, differ;
      rsp_type r;
      int i, j;
      elapsed = stamp - last_stamp;
      in_win = (elapsed > {12'd0, win_min}) && (elapsed < {8'd0, gap_max});
      if (last_stamp != 0 && elapsed > {8'd0, gap_max}) ph = PH_GEAR;
      case (ph)
         PH_DATA: begin
            if (in_win) begin
               hold_code = b;
               ph = PH_CHECK;
            end else if (b <= TOP_GEAR) begin
               hold_gear = b;
            end else begin
               ph = PH_GEAR;
            end
         end
         PH_CHECK: begin
            if (in_win) begin
               sum = hold_gear + hold_code;
               good = (b == sum);
               grp_total++;
               if (!good) bad_total++;
               r = '0;
               r.gear = hold_gear;
               r.code = hold_code;
               r.check = b;
               r.check_ok = good;
               r.groups_seen = grp_total;
               r.bad_checks = bad_total;
               stage_report(r);
               if (good) begin
                  if (cur_n == 0) cur_gear = hold_gear;
                  seen = 0;
                  for (i = 0; i < cur_n; i++)
                     if (cur_codes[i] == hold_code) seen = 1;
                  if (seen || (cur_n > 0 && hold_gear != cur_gear)) begin
                     if (cur_n > 0) begin
                        differ = (cur_gear != stat_gear) || (cur_n != stat_n);
                        for (i = 0; i < cur_n; i++) begin
                           hit = 0;
                           for (j = 0; j < stat_n; j++)
                              if (cur_codes[i] == stat_codes[j]) hit = 1;
                           if (!hit) differ = 1;
                        end
                        if (differ) begin
                           stat_gear = cur_gear;
                           stat_n = cur_n;
                           stat_codes = cur_codes;
                           for (i = 0; i < stat_n; i++) begin
                              r = '0;
                              r.kind = 1'b1;
                              r.gear = stat_gear;
                              r.code = stat_codes[i];
                              r.entry_index = 4'(i);
                              r.entry_total = 5'(stat_n);
                              r.update_ms = 23'(stamp / 32'd1000);
                              r.groups_seen = grp_total;
                              r.bad_checks = bad_total;
                              stage_report(r);
                           end
                        end
                     end
                     cur_gear = hold_gear;
                     cur_n = 0;
                  end
                  if (cur_n < CODE_SLOTS) begin
                     cur_codes[cur_n] = hold_code;
                     cur_n++;
                  end
               end
            end
            ph = PH_GEAR;
         end
         default: begin
            if (b <= TOP_GEAR) begin
               hold_gear = b;
               ph = PH_DATA;
            end else begin
               ph = PH_GEAR;
            end
         end
      endcase
      last_stamp = stamp;
      if (staged_full) begin
         staged.last = 1'b1;
         line_reports.push_back(staged);
         staged_full = 0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_reports.size() == 0) begin
            flag_mismatch("unexpected beat", 32'd0, 32'd0);
         end else begin
            want_rsp = line_reports.pop_front();
            if (rsp_data.kind !== want_rsp.kind)
               flag_mismatch("kind", 32'(rsp_data.kind), 32'(want_rsp.kind));
            if (rsp_data.last !== want_rsp.last)
               flag_mismatch("last", 32'(rsp_data.last), 32'(want_rsp.last));
            if (rsp_data.gear !== want_rsp.gear)
               flag_mismatch("gear", 32'(rsp_data.gear), 32'(want_rsp.gear));
            if (rsp_data.code !== want_rsp.code)
               flag_mismatch("code", 32'(rsp_data.code), 32'(want_rsp.code));
            if (rsp_data.check !== want_rsp.check)
               flag_mismatch("check", 32'(rsp_data.check), 32'(want_rsp.check));
            if (rsp_data.check_ok !== want_rsp.check_ok)
               flag_mismatch("check_ok", 32'(rsp_data.check_ok), 32'(want_rsp.check_ok));
            if (rsp_data.entry_index !== want_rsp.entry_index)
               flag_mismatch("entry_index", 32'(rsp_data.entry_index),
                             32'(want_rsp.entry_index));
            if (rsp_data.entry_total !== want_rsp.entry_total)
               flag_mismatch("entry_total", 32'(rsp_data.entry_total),
                             32'(want_rsp.entry_total));
            if (rsp_data.update_ms !== want_rsp.update_ms)
               flag_mismatch("update_ms", 32'(rsp_data.update_ms),
                             32'(want_rsp.update_ms));
            if (rsp_data.groups_seen !== want_rsp.groups_seen)
               flag_mismatch("groups_seen", rsp_data.groups_seen, want_rsp.groups_seen);
            if (rsp_data.bad_checks !== want_rsp.bad_checks)
               flag_mismatch("bad_checks", rsp_data.bad_checks, want_rsp.bad_checks);
         end
      end
   end

   // response backpressure: short bursts, some long holds, some free runs
   initial begin
      int pick;
      int hold;
      logic level;
      rsp_stall = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            level = 1'b0;
            hold = $urandom_range(1, 6);
         end else if (pick < 80) begin
            level = 1'b1;
            hold = $urandom_range(1, 3);
         end else if (pick < 93) begin
            level = 1'b0;
            hold = $urandom_range(20, 80);
         end else begin
            level = 1'b1;
            hold = $urandom_range(10, 40);
         end
         @(negedge clock);
         rsp_stall = level;
         repeat (hold - 1) @(negedge clock);
      end
   end

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] win_delta();
      int unsigned lo, hi;
      lo = {12'd0, win_min};
      hi = {8'd0, gap_max};
      if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
      return $urandom_range(1, 100);
   endfunction

   function automatic logic [31:0] rough_delta();
      int unsigned lo, hi;
      lo = {12'd0, win_min};
      hi = {8'd0, gap_max};
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, lo);
         1: return hi + $urandom_range(0, 1000);
         2: return $urandom();
         default: return win_delta();
      endcase
   endfunction

   // one byte beat on the request side, then a random idle gap
   task automatic next_byte(input logic [7:0] b, input logic [31:0] delta);
      int gap;
      line_time = line_time + delta;
      @(negedge clock);
      req_valid = 1'b1;
      req_data.rx_byte = b;
      req_data.stamp_us = line_time;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(b, line_time);
      bytes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_group(input logic [7:0] g, input logic [7:0] c, input bit good);
      logic [7:0] chk;
      chk = g + c;
      if (!good) chk = chk + 8'($urandom_range(1, 255));
      next_byte(g, win_delta());
      next_byte(c, win_delta());
      next_byte(chk, win_delta());
   endtask

   task automatic let_line_settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (line_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_timing(input logic [19:0] min_us, input logic [23:0] gap_us);
      let_line_settle();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_INTERBYTE_MIN;
      csr_wdata = {4'd0, min_us};
      @(negedge clock);
      csr_index = CSR_INTERGROUP_GAP;
      csr_wdata = gap_us;
      @(negedge clock);
      csr_we = 1'b0;
      win_min = min_us;
      gap_max = gap_us;
   endtask

   task automatic shake_line(input int count, input bit full_first);
      int goal, pick, i;
      logic [7:0] g, c;
      bit replay, full;
      full = full_first;
      goal = bytes_sent + count;
      while (bytes_sent < goal) begin
         pick = full ? 0 : $urandom_range(0, 99);
         if (pick < 70) begin
            replay = !full && mem_k > 0 && $urandom_range(0, 99) < 30;
            if (!replay) begin
               if ($urandom_range(0, 1)) mem_gear = 8'($urandom_range(0, 6));
               if (full || $urandom_range(0, 99) < 8) begin
                  mem_k = CODE_SLOTS + 1;
                  c = 8'($urandom_range(0, 255));
                  for (i = 0; i < mem_k; i++) mem_codes[i] = c + 8'(7 * i);
               end else begin
                  mem_k = $urandom_range(1, 4);
                  for (i = 0; i < mem_k; i++) mem_codes[i] = 8'($urandom_range(0, 255));
               end
            end
            full = 0;
            for (i = 0; i < mem_k; i++)
               send_group(mem_gear, mem_codes[i], $urandom_range(0, 99) < 95);
         end else if (pick < 85) begin
            next_byte(8'($urandom_range(0, 255)), rough_delta());
         end else if (pick < 93) begin
            g = 8'($urandom_range(0, 6));
            c = 8'($urandom_range(0, 255));
            next_byte(g, win_delta());
            if ($urandom_range(0, 1)) begin
               next_byte(c, rough_delta());
               next_byte(g + c, win_delta());
            end else begin
               next_byte(c, win_delta());
               next_byte(g + c, rough_delta());
            end
         end else begin
            send_group(8'($urandom_range(0, 6)), 8'($urandom_range(0, 255)), 0);
         end
      end
   endtask

   task automatic test_directed_cases();
      send_group(8'h00, 8'h00, 1);
      send_group(8'h06, 8'hFF, 1);          // gear change commits first cycle
      send_group(8'h06, 8'h12, 0);
      send_group(8'h06, 8'hFF, 1);          // repeated code commits
      next_byte(8'h03, 32'd5000);           // gear 3; the code after it is too soon, gear-like: regear
      next_byte(8'h02, 32'd1000);
      next_byte(8'h80, 32'd1000);           // too soon, not a gear: back to gear
      next_byte(8'h01, 32'd5000);
      next_byte(8'h07, 32'd5000);
      next_byte(8'h08, 32'd500);            // check too soon: dropped
      next_byte(8'h01, 32'd5000);
      next_byte(8'h09, 32'd60000);          // long gap restarts framing
      line_time = 32'hFFFF_EC77;
      next_byte(8'h02, 32'd0);
      next_byte(8'h03, 32'd5000);           // stamp all ones
      next_byte(8'h05, 32'd5001);           // wrapped stamp; cycle equals status
      line_time = 32'd0;
      next_byte(8'hFF, 32'd0);              // stamp zero leaves no history
      next_byte(8'h04, 32'd70000);
   endtask

   task automatic test_default_timing();
      program_timing(20'd2000, 24'd50000);
      shake_line(60, 1);
   endtask

   task automatic test_wide_window();
      program_timing(20'd0, 24'd10000000);
      shake_line(30, 0);
   endtask

   task automatic test_slow_line();
      program_timing(20'd1000000, 24'd10000000);
      shake_line(25, 0);
   endtask

   task automatic test_tight_window();
      program_timing(20'd100, 24'd3000);
      shake_line(25, 0);
   endtask

   task automatic test_closed_window();
      program_timing(20'd0, 24'd0);
      shake_line(10, 0);
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_default_timing();
      test_wide_window();
      test_slow_line();
      test_tight_window();
      test_closed_window();
      let_line_settle();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
